// ===== rtl/sliding_window_maximum_defines.svh =====
// Assertion macros shared by the sliding window maximum RTL.
// Standalone header: no dependencies; included by files that assert.
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm assertion failed");

`endif

// ===== rtl/swm_pkg.sv =====
// Package for the sliding window maximum: widths, FSM state type and
// controller/datapath command and status structs. No dependencies.
package swm_pkg;

    localparam int DATA_W         = 32;
    localparam int CFG_W          = 5;
    localparam int WINDOW_MAX_DEF = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic emit_now;
        logic need_scan;
        logic last_rd;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/swm_ifs.sv =====
// Valid/ready channel interfaces for sample input, result output and
// configuration write. Depends on swm_pkg.
interface swm_in_if;
    import swm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     sequence_start;
    modport source (output valid, output sample, output sequence_start, input ready);
    modport sink   (input valid, input sample, input sequence_start, output ready);
endinterface

interface swm_out_if;
    import swm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] window_max;
    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
    import swm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;
    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

// ===== rtl/sliding_window_maximum.sv =====
// Sliding window maximum over signed 32-bit samples; window 1..WINDOW_MAX.
// A new sample is taken only in idle, once the last one is through: the
// scan reads one history entry per cycle from the single RAM read port.
// Reset (synchronous, active low) clears window to 1, fill count and write pointer.
// Depends on swm_pkg, swm_ifs, swm_ctrl, swm_dp and swm_ram.
module sliding_window_maximum #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swm_in_if.sink    i_in,
    swm_cfg_if.sink   i_cfg,
    swm_out_if.source o_out
);
    import swm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The window register is a plain flop: a write transfer always lands.
    assign i_cfg.ready = 1'b1;

    // Controller: takes a sample in idle only; then drives the history scan
    // and waits until the output register is free before loading it, so a
    // result never overtakes or overwrites one still waiting downstream.
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: writes the new sample at the write pointer, walks back
    // through the previous window-1 entries and keeps the signed maximum.
    // The output register parts the two sides, so a new sample transfer is
    // taken while the last result still waits to be taken.
    swm_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg.valid),
        .i_window_size    (i_cfg.window_size),
        .i_sample         (i_in.sample),
        .i_sequence_start (i_in.sequence_start),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_window_max     (o_out.window_max)
    );

endmodule

// ===== rtl/swm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/swm_ctrl.sv =====
// Controller FSM for the sliding window maximum: accept, scan history,
// hand the result to the output register. Depends on swm_pkg.
module swm_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  swm_pkg::t_sts i_sts,
    output swm_pkg::t_cmd o_cmd
);
    import swm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit_now) begin
                        n_state = i_sts.need_scan ? ST_SCAN : ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.last_rd) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read data is compared at this edge
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/swm_dp.sv =====
// Datapath for the sliding window maximum: window register, history RAM,
// pointers, fill count, running maximum and output register.
// Depends on swm_pkg, swm_ram and the assertion macro header.
`include "sliding_window_maximum_defines.svh"

module swm_dp #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]        i_window_size,
    input  logic signed [swm_pkg::DATA_W-1:0] i_sample,
    input  logic                             i_sequence_start,
    input  swm_pkg::t_cmd                    i_cmd,
    output swm_pkg::t_sts                    o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [swm_pkg::DATA_W-1:0] o_window_max
);
    import swm_pkg::*;

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [KW-1:0]    WMAX_K   = KW'(WINDOW_MAX);
    localparam logic [CNT_W-1:0] WMAX_C   = CNT_W'(WINDOW_MAX);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_MAX - 1);

    logic [CFG_W-1:0]         r_window_size;
    logic [CNT_W-1:0]         r_fill;
    logic [PTR_W-1:0]         r_wptr;
    logic [PTR_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_remain;
    logic                     r_rd_vld;
    logic signed [DATA_W-1:0] r_best;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;

    logic [KW-1:0]            ws_ext;
    logic [KW-1:0]            k_wide;
    logic [CNT_W-1:0]         k;
    logic [CNT_W-1:0]         n_fill;
    logic [PTR_W-1:0]         wptr_inc;
    logic [PTR_W-1:0]         pos_dec;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] rd_sample;

    // Clamp the window to 1..WINDOW_MAX
    always_comb begin
        ws_ext = KW'(r_window_size);
        if (ws_ext == '0) begin
            k_wide = KW'(1);
        end else if (ws_ext > WMAX_K) begin
            k_wide = WMAX_K;
        end else begin
            k_wide = ws_ext;
        end
        k = k_wide[CNT_W-1:0];
    end

    always_comb begin
        if (i_sequence_start) begin
            n_fill = CNT_W'(1);
        end else if (r_fill < WMAX_C) begin
            n_fill = r_fill + CNT_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    assign wptr_inc = (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
    assign pos_dec  = (r_pos == '0) ? LAST_PTR : r_pos - PTR_W'(1);

    assign o_sts.emit_now  = (n_fill >= k);
    assign o_sts.need_scan = (k > CNT_W'(1));
    assign o_sts.last_rd   = (r_remain == CNT_W'(1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    swm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_wptr),
        .i_wdata (i_sample),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (pos_dec),
        .o_rdata (rd_data)
    );

    assign rd_sample = $signed(rd_data);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_W'(1);
            r_fill        <= '0;
            r_wptr        <= '0;
            r_remain      <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_size <= i_window_size;
            end
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.accept) begin
                r_fill   <= n_fill;
                r_wptr   <= wptr_inc;
                r_remain <= k - CNT_W'(1);
            end else if (i_cmd.rd_issue) begin
                r_remain <= r_remain - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos  <= r_wptr;
            r_best <= i_sample;
        end else begin
            if (i_cmd.rd_issue) begin
                r_pos <= pos_dec;
            end
            if (r_rd_vld && (rd_sample > r_best)) begin
                r_best <= rd_sample;
            end
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_best;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

    `SWM_ASSERT_IMPL(a_rd_in_window, i_clk, i_rst_n, i_cmd.rd_issue, r_remain != '0)
    `SWM_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.load_out, o_sts.out_free)
    `SWM_ASSERT_NEXT(a_fill_bound, i_clk, i_rst_n, i_cmd.accept, (r_fill <= WMAX_C) && (r_fill != '0))

endmodule
